// ===== rtl/lbs_pkg.sv =====
// Shared types, constants and opcodes of the vertex skinning block.
`default_nettype none

package lbs_pkg;

    localparam int NUM_BONES_DEF = 64;
    localparam int MAX_INFL_DEF  = 4;

    // Palette layout: 12 elements per bone, element = row*3 + col, row 3 is translation
    localparam int ELEMS      = 12;
    localparam int COLS       = 3;
    localparam int TRANS_BASE = 9;

    localparam int MAT_W  = 24;
    localparam int VEC_W  = 16;
    localparam int W_W    = 8;
    localparam int IDX_W  = 6;
    localparam int BONE_W = 8;
    localparam int ELEM_W = 4;
    localparam int TEX_W  = 32;

    localparam int PROD_W      = MAT_W + VEC_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int WPROD_W     = SUM_W + W_W + 1;
    localparam int TERM_W      = SUM_W + W_W;
    localparam int ACC_W       = TERM_W + 2;
    localparam int TRANS_SHIFT = 12;
    localparam int FRAC_SHIFT  = 16;
    localparam int B_W         = ACC_W - FRAC_SHIFT;

    // Rounding and division by 255 after the 2^16 shift
    localparam logic signed [ACC_W-1:0] HALF_D  = ACC_W'(255 * 32768);
    localparam logic signed [B_W-1:0]   SAT_HI  = B_W'(32767 * 255 + 254);
    localparam logic signed [B_W-1:0]   SAT_LO  = -B_W'(32768 * 255);
    localparam logic signed [B_W-1:0]   SAT_OFS = B_W'(32768 * 255);
    localparam int U_W         = 24;
    localparam int RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP255 = RECIP_W'(16843010);
    localparam int RPROD_W     = U_W + RECIP_W;
    localparam int RECIP_SHIFT = 32;
    localparam logic [VEC_W-1:0] SAT_POS = 16'h7fff;
    localparam logic [VEC_W-1:0] SAT_NEG = 16'h8000;

    // Load address split: addr/12 as (addr*2731)>>15, exact for addr below 4096
    localparam int ADDR_LOW_W    = 12;
    localparam int RECIP12_W     = 12;
    localparam logic [RECIP12_W-1:0] RECIP12 = RECIP12_W'(2731);
    localparam int RECIP12_SHIFT = 15;

    localparam int NUM_STAGES = 8;
    typedef logic [NUM_STAGES:1] stage_vec_t;

    typedef logic [ELEMS-1:0][MAT_W-1:0] bone_mat_t;
    typedef logic [COLS-1:0][VEC_W-1:0]  vec3_t;
    typedef logic [COLS-1:0][TERM_W-1:0] term3_t;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_SKIN1 = 3'd1,
        OP_SKIN2 = 3'd2,
        OP_SKIN3 = 3'd3,
        OP_SKIN4 = 3'd4
    } opcode_t;

endpackage

`default_nettype wire

// ===== rtl/lbs_palette.sv =====
// One copy of the bone palette: one memory per matrix element, registered read.
`default_nettype none

module lbs_palette
    import lbs_pkg::*;
#(
    parameter int NUM_BONES = NUM_BONES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [BONE_W-1:0] wr_bone,
    input  wire logic [ELEM_W-1:0] wr_elem,
    input  wire logic [MAT_W-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic              rd_use,
    input  wire logic [BONE_W-1:0] rd_bone,
    output bone_mat_t              rd_mat
);

    localparam int BONE_AW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;

    logic rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_ok_reg <= rd_use && (32'(rd_bone) < NUM_BONES);
        end
    end

    for (genvar e = 0; e < ELEMS; e++)
    begin : g_elem
        logic [MAT_W-1:0] mem_reg [NUM_BONES];
        logic [MAT_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_elem == ELEM_W'(e)))
            begin
                mem_reg[wr_bone[BONE_AW-1:0]] <= wr_data;
            end
            if (rd_en)
            begin
                rd_reg <= mem_reg[rd_bone[BONE_AW-1:0]];
            end
        end

        // out-of-range bone or unused influence contributes a zero matrix
        assign rd_mat[e] = rd_ok_reg ? rd_reg : '0;
    end

endmodule

`default_nettype wire

// ===== rtl/lbs_lane.sv =====
// One influence lane: matrix products, row sums and weight scaling (stages 2 to 4).
`default_nettype none

module lbs_lane
    import lbs_pkg::*;
(
    input  wire logic           clk,
    input  wire stage_vec_t     stage_en,
    input  wire bone_mat_t      mat,
    input  wire vec3_t          pos,
    input  wire vec3_t          norm,
    input  wire logic [W_W-1:0] weight,
    output term3_t              term_pos,
    output term3_t              term_norm
);

    logic signed [PROD_W-1:0]  prod_p_reg [COLS][COLS];
    logic signed [PROD_W-1:0]  prod_n_reg [COLS][COLS];
    logic signed [MAT_W-1:0]   trans_reg  [COLS];
    logic signed [SUM_W-1:0]   sum_p_reg  [COLS];
    logic signed [SUM_W-1:0]   sum_n_reg  [COLS];
    logic signed [WPROD_W-1:0] wprod_p    [COLS];
    logic signed [WPROD_W-1:0] wprod_n    [COLS];
    logic [W_W-1:0]            w2_reg;
    logic [W_W-1:0]            w3_reg;
    term3_t                    term_p_reg;
    term3_t                    term_n_reg;

    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            wprod_p[c] = sum_p_reg[c] * $signed({1'b0, w3_reg});
            wprod_n[c] = sum_n_reg[c] * $signed({1'b0, w3_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            for (int r = 0; r < COLS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    prod_p_reg[r][c] <= $signed(pos[r]) * $signed(mat[r * COLS + c]);
                    prod_n_reg[r][c] <= $signed(norm[r]) * $signed(mat[r * COLS + c]);
                end
            end
            for (int c = 0; c < COLS; c++)
            begin
                trans_reg[c] <= $signed(mat[TRANS_BASE + c]);
            end
            w2_reg <= weight;
        end
        if (stage_en[3])
        begin
            for (int c = 0; c < COLS; c++)
            begin
                sum_p_reg[c] <= SUM_W'(prod_p_reg[0][c]) + SUM_W'(prod_p_reg[1][c])
                              + SUM_W'(prod_p_reg[2][c])
                              + (SUM_W'(trans_reg[c]) <<< TRANS_SHIFT);
                sum_n_reg[c] <= SUM_W'(prod_n_reg[0][c]) + SUM_W'(prod_n_reg[1][c])
                              + SUM_W'(prod_n_reg[2][c]);
            end
            w3_reg <= w2_reg;
        end
        if (stage_en[4])
        begin
            for (int c = 0; c < COLS; c++)
            begin
                term_p_reg[c] <= wprod_p[c][TERM_W-1:0];
                term_n_reg[c] <= wprod_n[c][TERM_W-1:0];
            end
        end
    end

    assign term_pos  = term_p_reg;
    assign term_norm = term_n_reg;

endmodule

`default_nettype wire

// ===== rtl/lbs_round.sv =====
// Round-to-nearest divide by 255*2^16 and saturation of one component (stages 5 to 8).
`default_nettype none

module lbs_round
    import lbs_pkg::*;
(
    input  wire logic                    clk,
    input  wire stage_vec_t              stage_en,
    input  wire logic signed [ACC_W-1:0] sum_in,
    output logic [VEC_W-1:0]             result
);

    logic signed [ACC_W-1:0] biased;
    logic signed [B_W-1:0]   b_reg;
    logic signed [B_W-1:0]   shifted;
    logic [U_W-1:0]          u_reg;
    logic                    hi6_reg;
    logic                    lo6_reg;
    logic [RPROD_W-1:0]      p_reg;
    logic                    hi7_reg;
    logic                    lo7_reg;
    logic [VEC_W-1:0]        quot;
    logic [VEC_W-1:0]        res_reg;

    assign biased  = sum_in + HALF_D;
    assign shifted = b_reg + SAT_OFS;
    assign quot    = p_reg[RECIP_SHIFT +: VEC_W];

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            b_reg <= biased[ACC_W-1:FRAC_SHIFT];
        end
        if (stage_en[6])
        begin
            hi6_reg <= (b_reg > SAT_HI);
            lo6_reg <= (b_reg < SAT_LO);
            u_reg   <= shifted[U_W-1:0];
        end
        if (stage_en[7])
        begin
            p_reg   <= RPROD_W'(u_reg) * RPROD_W'(RECIP255);
            hi7_reg <= hi6_reg;
            lo7_reg <= lo6_reg;
        end
        if (stage_en[8])
        begin
            // quotient carries a +32768 offset: flip the top bit to remove it
            priority if (hi7_reg)
            begin
                res_reg <= SAT_POS;
            end
            else if (lo7_reg)
            begin
                res_reg <= SAT_NEG;
            end
            else
            begin
                res_reg <= {~quot[VEC_W-1], quot[VEC_W-2:0]};
            end
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// ===== rtl/linear_blend_vertex_skinning.sv =====
// Top level of the four-bone linear blend vertex skinning pipeline.
`default_nettype none

// Linear blend skinning with up to four bone influences. Load requests (opcode 0)
// write one Q8.16 palette element at address bone*12+element; skin requests
// (opcode 1..MAX_INFLUENCES) return one skinned vertex, other opcodes return nothing.
// The block takes one request per cycle while out_ready does not stall the output;
// each influence has its own palette copy with one registered read port,
// which is what lets all influences be fetched in the same cycle. A load is visible
// to the very next skin request. The palette is not cleared at reset: every bone
// that a skin request uses must be loaded first.
module linear_blend_vertex_skinning
    import lbs_pkg::*;
#(
    parameter int NUM_BONES      = NUM_BONES_DEF,
    parameter int MAX_INFLUENCES = MAX_INFL_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [23:0] index_word,
    input  wire logic [23:0] matrix_value,
    input  wire logic [31:0] weights,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [15:0] pos_z,
    input  wire logic [15:0] norm_x,
    input  wire logic [15:0] norm_y,
    input  wire logic [15:0] norm_z,
    input  wire logic [31:0] texcoords,
    input  wire logic        last_vertex,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_pos_x,
    output logic [15:0]      out_pos_y,
    output logic [15:0]      out_pos_z,
    output logic [15:0]      out_norm_x,
    output logic [15:0]      out_norm_y,
    output logic [15:0]      out_norm_z,
    output logic [31:0]      out_texcoords,
    output logic             out_last
);

    stage_vec_t valid_reg;
    stage_vec_t valid_next;
    stage_vec_t stage_en;

    logic                   skin_ok;
    logic                   addr_ok;
    logic                   wr_en;
    logic [ADDR_LOW_W-1:0]  addr_low;
    logic [ADDR_LOW_W+RECIP12_W-1:0] addr_prod;
    logic [BONE_W-1:0]      wr_bone;
    logic [ADDR_LOW_W-1:0]  elem_full;
    logic [ELEM_W-1:0]      wr_elem;

    logic [W_W-1:0]         w_sel [MAX_INFLUENCES];
    logic [W_W-1:0]         w_reg [MAX_INFLUENCES];
    vec3_t                  pos_reg;
    vec3_t                  norm_reg;
    logic [TEX_W-1:0]       tex_reg  [NUM_STAGES:1];
    logic                   last_reg [NUM_STAGES:1];

    bone_mat_t              mat      [MAX_INFLUENCES];
    term3_t                 term_pos [MAX_INFLUENCES];
    term3_t                 term_norm[MAX_INFLUENCES];
    logic signed [ACC_W-1:0] acc_p   [COLS];
    logic signed [ACC_W-1:0] acc_n   [COLS];
    logic [VEC_W-1:0]       res_p    [COLS];
    logic [VEC_W-1:0]       res_n    [COLS];

    // A stage advances when it is empty or the stage after it advances
    always_comb
    begin
        stage_en[NUM_STAGES] = !valid_reg[NUM_STAGES] || out_ready;
        for (int i = NUM_STAGES - 1; i >= 1; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i + 1];
        end
    end

    assign in_ready = stage_en[1];
    assign skin_ok  = (opcode != OP_LOAD) && (32'(opcode) <= MAX_INFLUENCES);

    always_comb
    begin
        valid_next[1] = stage_en[1] ? (in_valid && skin_ok) : valid_reg[1];
        for (int i = 2; i <= NUM_STAGES; i++)
        begin
            valid_next[i] = stage_en[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Palette write: split address into bone and element
    assign addr_ok   = (32'(index_word) < NUM_BONES * ELEMS);
    assign addr_low  = index_word[ADDR_LOW_W-1:0];
    assign addr_prod = (ADDR_LOW_W + RECIP12_W)'(addr_low)
                     * (ADDR_LOW_W + RECIP12_W)'(RECIP12);
    assign wr_bone   = addr_prod[RECIP12_SHIFT +: BONE_W];
    assign elem_full = addr_low - (ADDR_LOW_W'(wr_bone) * ADDR_LOW_W'(ELEMS));
    assign wr_elem   = elem_full[ELEM_W-1:0];
    assign wr_en     = in_valid && stage_en[1] && (opcode == OP_LOAD) && addr_ok;

    // Effective weights: a single influence uses its bone unscaled
    always_comb
    begin
        for (int k = 0; k < MAX_INFLUENCES; k++)
        begin
            if (opcode == OP_SKIN1)
            begin
                w_sel[k] = (k == 0) ? W_W'(255) : '0;
            end
            else if (32'(k) < 32'(opcode))
            begin
                w_sel[k] = weights[k * W_W +: W_W];
            end
            else
            begin
                w_sel[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            for (int k = 0; k < MAX_INFLUENCES; k++)
            begin
                w_reg[k] <= w_sel[k];
            end
            pos_reg     <= {pos_z, pos_y, pos_x};
            norm_reg    <= {norm_z, norm_y, norm_x};
            tex_reg[1]  <= texcoords;
            last_reg[1] <= last_vertex;
        end
        for (int i = 2; i <= NUM_STAGES; i++)
        begin
            if (stage_en[i])
            begin
                tex_reg[i]  <= tex_reg[i - 1];
                last_reg[i] <= last_reg[i - 1];
            end
        end
    end

    for (genvar k = 0; k < MAX_INFLUENCES; k++)
    begin : g_lane
        lbs_palette #(
            .NUM_BONES (NUM_BONES)
        ) u_palette (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_bone (wr_bone),
            .wr_elem (wr_elem),
            .wr_data (matrix_value),
            .rd_en   (stage_en[1]),
            .rd_use  (skin_ok && (32'(opcode) > 32'(k))),
            .rd_bone (BONE_W'(index_word[k * IDX_W +: IDX_W])),
            .rd_mat  (mat[k])
        );

        lbs_lane u_lane (
            .clk       (clk),
            .stage_en  (stage_en),
            .mat       (mat[k]),
            .pos       (pos_reg),
            .norm      (norm_reg),
            .weight    (w_reg[k]),
            .term_pos  (term_pos[k]),
            .term_norm (term_norm[k])
        );
    end

    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            acc_p[c] = '0;
            acc_n[c] = '0;
            for (int k = 0; k < MAX_INFLUENCES; k++)
            begin
                acc_p[c] = acc_p[c] + ACC_W'($signed(term_pos[k][c]));
                acc_n[c] = acc_n[c] + ACC_W'($signed(term_norm[k][c]));
            end
        end
    end

    for (genvar c = 0; c < COLS; c++)
    begin : g_comp
        lbs_round u_round_pos (
            .clk      (clk),
            .stage_en (stage_en),
            .sum_in   (acc_p[c]),
            .result   (res_p[c])
        );

        lbs_round u_round_norm (
            .clk      (clk),
            .stage_en (stage_en),
            .sum_in   (acc_n[c]),
            .result   (res_n[c])
        );
    end

    assign out_valid     = valid_reg[NUM_STAGES];
    assign out_pos_x     = res_p[0];
    assign out_pos_y     = res_p[1];
    assign out_pos_z     = res_p[2];
    assign out_norm_x    = res_n[0];
    assign out_norm_y    = res_n[1];
    assign out_norm_z    = res_n[2];
    assign out_texcoords = tex_reg[NUM_STAGES];
    assign out_last      = last_reg[NUM_STAGES];

endmodule

`default_nettype wire
